/* design/mhtq_pkg.sv */
// ----------------------------------------------------------------------------
// mhtq_pkg
// Types and constants shared by the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int Capacity = 64;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CountW   = AddrW + 1;
  localparam int MaxRes   = 64;
  localparam int ResW     = $clog2(MaxRes + 1);
  localparam int KeyW     = 32;
  localparam int IdW      = 16;
  localparam int EntryW   = KeyW + IdW + 1;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_ADJUST = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  localparam logic RES_EXPIRED = 1'b0;
  localparam logic RES_FULL    = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdW-1:0]  id;
    logic            live;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FULL,
    ST_UP_RD,
    ST_UP_CMP,
    ST_UP_FIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_OUT,
    ST_TICK_MOVE,
    ST_TICK_LOAD,
    ST_TICK_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DN_FIN
  } state_t;

endpackage

/* design/mhtq_if.sv */
// ----------------------------------------------------------------------------
// mhtq_in_if / mhtq_out_if
// Valid/ready channels for timer commands and timer events.
// ----------------------------------------------------------------------------
interface mhtq_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [mhtq_pkg::IdW-1:0]  conn_id;
  logic [mhtq_pkg::KeyW-1:0] expire_time;
  logic [mhtq_pkg::KeyW-1:0] now_time;
  modport source (output valid, kind, conn_id, expire_time, now_time, input ready);
  modport sink (input valid, kind, conn_id, expire_time, now_time, output ready);
endinterface

interface mhtq_out_if;
  logic                     valid;
  logic                     ready;
  logic                     event_res;
  logic [mhtq_pkg::IdW-1:0] expired_id;
  logic                     last;
  modport source (output valid, event_res, expired_id, last, input ready);
  modport sink (input valid, event_res, expired_id, last, output ready);
endinterface

/* design/mhtq_ram.sv */
// ----------------------------------------------------------------------------
// mhtq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mhtq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* design/min_heap_timer_queue.sv */
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Binary min-heap of timers with add, lazy cancel, adjust and tick.
// ----------------------------------------------------------------------------
// Usage: commands enter on cmd (kind, conn_id, expire_time, now_time); timer
// events leave on evt (event_res, expired_id, last). A command is taken only
// when the block is idle; ready stays low until all its work and events are
// done. The heap lives in one single-port RAM, one access per cycle.
// Add: compares each parent in turn (at most log2(64)=6), then one write.
// Cancel: scans every entry held. Adjust: scans every entry and sifts each
// matching entry down.
// Tick: pops each expired root, moves the last entry into the root and sifts
// it down, with one beat for each expired event but the final one; the tick
// ends with a root check and, if any event expired, the final beat (last = 1).
// A stalled evt holds the sequencer in place; nothing is dropped.
// Rejected adds (heap full) give one event beat with event_res 1.
// Reset clears the entry count; RAM contents need no clearing since only
// entries below the count are read.
// ----------------------------------------------------------------------------
module min_heap_timer_queue (
  input logic        clk,
  input logic        rst,
  mhtq_in_if.sink    cmd,
  mhtq_out_if.source evt
);
  localparam int AW = mhtq_pkg::AddrW;
  localparam int CW = mhtq_pkg::CountW;

  mhtq_pkg::state_t state, state_next;

  logic [CW-1:0]             count;
  logic [CW-1:0]             pos;       // hole / sift position
  logic [CW-1:0]             scan;
  logic [mhtq_pkg::ResW-1:0] nres;
  mhtq_pkg::kind_t           kind;
  logic [mhtq_pkg::IdW-1:0]  id;
  logic [mhtq_pkg::KeyW-1:0] exp_t, now_t;
  mhtq_pkg::entry_t          carry;     // entry being sifted
  mhtq_pkg::entry_t          left_e;
  logic                      pend;      // one expired event held back to learn 'last'
  logic [mhtq_pkg::IdW-1:0]  pend_id;
  logic [mhtq_pkg::IdW-1:0]  tick_id;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  mhtq_pkg::entry_t ram_wdata, ram_rdata;

  logic [CW-1:0]    parent;
  logic [CW:0]      lchild, rchild;
  logic             up_move, scan_hit, scan_last, take_right, dn_move, pop_hit;
  mhtq_pkg::entry_t best_e;

  mhtq_ram #(.Width(mhtq_pkg::EntryW), .Depth(mhtq_pkg::Capacity)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign parent    = (pos - CW'(1)) >> 1;
  assign lchild    = {pos, 1'b1};
  assign rchild    = lchild + (CW+1)'(1);
  assign up_move   = (ram_rdata.key > exp_t);
  assign scan_hit  = (ram_rdata.id == id);
  assign scan_last = (scan + CW'(1) >= count);
  // in DN_CMP rdata holds the right child, left_e the left one
  assign take_right = (rchild < {1'b0, count}) && (ram_rdata.key < left_e.key);
  assign best_e     = take_right ? ram_rdata : left_e;
  assign dn_move    = (best_e.key < carry.key);
  assign pop_hit    = (count != '0) && (ram_rdata.key <= now_t) &&
                      (nres != mhtq_pkg::ResW'(mhtq_pkg::MaxRes));

  always_comb begin
    state_next = state;
    unique case (state)
      mhtq_pkg::ST_IDLE: if (cmd.valid) begin
        unique case (mhtq_pkg::kind_t'(cmd.kind))
          mhtq_pkg::KIND_ADD:
            state_next = (count >= CW'(mhtq_pkg::Capacity)) ? mhtq_pkg::ST_FULL
                       : (count == '0) ? mhtq_pkg::ST_UP_FIN : mhtq_pkg::ST_UP_RD;
          mhtq_pkg::KIND_CANCEL:
            state_next = (count == '0) ? mhtq_pkg::ST_IDLE : mhtq_pkg::ST_SCAN_RD;
          mhtq_pkg::KIND_ADJUST:
            state_next = (count == '0) ? mhtq_pkg::ST_IDLE : mhtq_pkg::ST_SCAN_RD;
          default:
            state_next = (count == '0) ? mhtq_pkg::ST_IDLE : mhtq_pkg::ST_TICK_RD;
        endcase
      end
      mhtq_pkg::ST_FULL: if (evt.ready) state_next = mhtq_pkg::ST_IDLE;
      mhtq_pkg::ST_UP_RD: state_next = mhtq_pkg::ST_UP_CMP;
      mhtq_pkg::ST_UP_CMP:
        state_next = (up_move && parent != '0) ? mhtq_pkg::ST_UP_RD : mhtq_pkg::ST_UP_FIN;
      mhtq_pkg::ST_UP_FIN: state_next = mhtq_pkg::ST_IDLE;
      mhtq_pkg::ST_SCAN_RD: state_next = mhtq_pkg::ST_SCAN_CHK;
      mhtq_pkg::ST_SCAN_CHK:
        if (scan_hit && kind == mhtq_pkg::KIND_ADJUST) state_next = mhtq_pkg::ST_DN_RDL;
        else if (scan_last) state_next = mhtq_pkg::ST_IDLE;
        else state_next = mhtq_pkg::ST_SCAN_RD;
      mhtq_pkg::ST_TICK_RD: state_next = mhtq_pkg::ST_TICK_CHK;
      mhtq_pkg::ST_TICK_CHK:
        if (pop_hit)
          state_next = (ram_rdata.live && pend) ? mhtq_pkg::ST_TICK_OUT
                                                : mhtq_pkg::ST_TICK_MOVE;
        else state_next = pend ? mhtq_pkg::ST_TICK_LAST : mhtq_pkg::ST_IDLE;
      mhtq_pkg::ST_TICK_OUT: if (evt.ready) state_next = mhtq_pkg::ST_TICK_MOVE;
      mhtq_pkg::ST_TICK_MOVE: state_next = mhtq_pkg::ST_TICK_LOAD;
      mhtq_pkg::ST_TICK_LOAD: state_next = mhtq_pkg::ST_DN_RDL;
      mhtq_pkg::ST_TICK_LAST: if (evt.ready) state_next = mhtq_pkg::ST_IDLE;
      mhtq_pkg::ST_DN_RDL:
        state_next = (lchild < {1'b0, count}) ? mhtq_pkg::ST_DN_RDR : mhtq_pkg::ST_DN_FIN;
      mhtq_pkg::ST_DN_RDR: state_next = mhtq_pkg::ST_DN_CMP;
      mhtq_pkg::ST_DN_CMP:
        state_next = dn_move ? mhtq_pkg::ST_DN_RDL : mhtq_pkg::ST_DN_FIN;
      mhtq_pkg::ST_DN_FIN:
        if (kind == mhtq_pkg::KIND_TICK) state_next = mhtq_pkg::ST_TICK_RD;
        else if (scan_last) state_next = mhtq_pkg::ST_IDLE;
        else state_next = mhtq_pkg::ST_SCAN_RD;
      default: state_next = mhtq_pkg::ST_IDLE;
    endcase
  end

  // RAM port and handshake outputs
  always_comb begin
    ram_we         = 1'b0;
    ram_addr       = pos[AW-1:0];
    ram_wdata      = carry;
    cmd.ready      = (state == mhtq_pkg::ST_IDLE);
    evt.valid      = 1'b0;
    evt.event_res  = mhtq_pkg::RES_EXPIRED;
    evt.expired_id = pend_id;
    evt.last       = 1'b0;
    unique case (state)
      mhtq_pkg::ST_FULL: begin
        evt.valid      = 1'b1;
        evt.event_res  = mhtq_pkg::RES_FULL;
        evt.expired_id = id;
        evt.last       = 1'b1;
      end
      mhtq_pkg::ST_UP_RD: ram_addr = parent[AW-1:0];
      mhtq_pkg::ST_UP_CMP: begin
        ram_we    = up_move;
        ram_wdata = ram_rdata;
      end
      mhtq_pkg::ST_UP_FIN: ram_we = 1'b1;
      mhtq_pkg::ST_SCAN_RD: ram_addr = scan[AW-1:0];
      mhtq_pkg::ST_SCAN_CHK: begin
        ram_addr = scan[AW-1:0];
        ram_we = scan_hit && (kind == mhtq_pkg::KIND_CANCEL);
        ram_wdata = ram_rdata;
        ram_wdata.live = 1'b0;
      end
      mhtq_pkg::ST_TICK_RD: ram_addr = '0;
      mhtq_pkg::ST_TICK_OUT: evt.valid = 1'b1;
      mhtq_pkg::ST_TICK_MOVE: ram_addr = count[AW-1:0];
      mhtq_pkg::ST_TICK_LAST: begin
        evt.valid = 1'b1;
        evt.last  = 1'b1;
      end
      mhtq_pkg::ST_DN_RDL: ram_addr = lchild[AW-1:0];
      mhtq_pkg::ST_DN_RDR: ram_addr = rchild[AW-1:0];
      mhtq_pkg::ST_DN_CMP: begin
        ram_we    = dn_move;
        ram_wdata = best_e;
      end
      mhtq_pkg::ST_DN_FIN: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhtq_pkg::ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        mhtq_pkg::ST_IDLE: if (cmd.valid) begin
          kind  <= mhtq_pkg::kind_t'(cmd.kind);
          id    <= cmd.conn_id;
          exp_t <= cmd.expire_time;
          now_t <= cmd.now_time;
          carry <= '{key: cmd.expire_time, id: cmd.conn_id, live: 1'b1};
          scan  <= '0;
          nres  <= '0;
          pend  <= 1'b0;
          pos   <= count;
          if (mhtq_pkg::kind_t'(cmd.kind) == mhtq_pkg::KIND_ADD &&
              count < CW'(mhtq_pkg::Capacity))
            count <= count + CW'(1);
        end
        mhtq_pkg::ST_UP_CMP:
          if (up_move) pos <= parent;
        mhtq_pkg::ST_SCAN_CHK: begin
          if (scan_hit && kind == mhtq_pkg::KIND_ADJUST) begin
            carry <= '{key: exp_t, id: ram_rdata.id, live: ram_rdata.live};
            pos   <= scan;
          end else begin
            scan <= scan + CW'(1);
          end
        end
        mhtq_pkg::ST_TICK_CHK:
          if (pop_hit) begin
            count <= count - CW'(1);
            if (ram_rdata.live) begin
              nres <= nres + mhtq_pkg::ResW'(1);
              if (pend) begin
                tick_id <= ram_rdata.id;
              end else begin
                pend    <= 1'b1;
                pend_id <= ram_rdata.id;
              end
            end
          end
        mhtq_pkg::ST_TICK_OUT:
          if (evt.ready) pend_id <= tick_id;
        // last entry moves into the root and sifts down from there
        mhtq_pkg::ST_TICK_LOAD: begin
          carry <= ram_rdata;
          pos   <= '0;
        end
        mhtq_pkg::ST_TICK_LAST:
          if (evt.ready) pend <= 1'b0;
        mhtq_pkg::ST_DN_RDR: left_e <= ram_rdata;
        mhtq_pkg::ST_DN_CMP:
          if (dn_move) pos <= take_right ? rchild[CW-1:0] : lchild[CW-1:0];
        mhtq_pkg::ST_DN_FIN:
          if (kind != mhtq_pkg::KIND_TICK) scan <= scan + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the min-heap timer queue against a behavioral heap model: random
// streams of add, cancel, adjust and tick with random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  localparam int IdW      = mhtq_pkg::IdW;
  localparam int KeyW     = mhtq_pkg::KeyW;
  localparam int Capacity = mhtq_pkg::Capacity;
  localparam int MaxRes   = mhtq_pkg::MaxRes;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdW-1:0]  conn_id;
    logic [KeyW-1:0] expire_time;
    logic [KeyW-1:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic           event_res;
    logic [IdW-1:0] expired_id;
    logic           last;
  } timer_evt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mhtq_in_if  cmd ();
  mhtq_out_if evt ();

  min_heap_timer_queue dut (.clk(clk), .rst(rst), .cmd(cmd), .evt(evt));

  initial begin
    forever #1 clk = ~clk;
  end

  // behavioral heap
  logic [KeyW-1:0] hk [Capacity];
  logic [IdW-1:0]  hid [Capacity];
  logic            hlv [Capacity];
  int              hcount;

  cmd_t       cmd_q [$];
  timer_evt_t evt_q [$];
  int errors;
  int n_evt;
  int n_full;
  bit quiet;    // no idling on either side
  bit hold_tx;  // sender holds off

  function automatic void heap_sift_down(int pos);
    logic [KeyW-1:0] k;
    logic [IdW-1:0]  id;
    logic            lv;
    int c;
    k = hk[pos]; id = hid[pos]; lv = hlv[pos];
    while (pos * 2 + 1 < hcount) begin
      c = pos * 2 + 1;
      if (c + 1 < hcount && hk[c + 1] < hk[c]) c++;
      if (hk[c] < k) begin
        hk[pos] = hk[c]; hid[pos] = hid[c]; hlv[pos] = hlv[c];
        pos = c;
      end else begin
        break;
      end
    end
    hk[pos] = k; hid[pos] = id; hlv[pos] = lv;
  endfunction

  function automatic void predict_timer_events(cmd_t c);
    int hole, parent, n;
    timer_evt_t e;
    n = 0;
    case (mhtq_pkg::kind_t'(c.kind))
      mhtq_pkg::KIND_ADD: begin
        if (hcount >= Capacity) begin
          e.event_res = mhtq_pkg::RES_FULL; e.expired_id = c.conn_id; e.last = 1'b1;
          evt_q.push_back(e);
        end else begin
          hole = hcount;
          hcount++;
          while (hole > 0) begin
            parent = (hole - 1) / 2;
            if (hk[parent] <= c.expire_time) break;
            hk[hole] = hk[parent]; hid[hole] = hid[parent]; hlv[hole] = hlv[parent];
            hole = parent;
          end
          hk[hole] = c.expire_time; hid[hole] = c.conn_id; hlv[hole] = 1'b1;
        end
      end
      mhtq_pkg::KIND_CANCEL: begin
        for (int i = 0; i < hcount; i++)
          if (hid[i] == c.conn_id) hlv[i] = 1'b0;
      end
      mhtq_pkg::KIND_ADJUST: begin
        for (int i = 0; i < hcount; i++)
          if (hid[i] == c.conn_id) begin
            hk[i] = c.expire_time;
            heap_sift_down(i);
          end
      end
      default: begin
        while (hcount > 0 && n < MaxRes && hk[0] <= c.now_time) begin
          if (hlv[0]) begin
            e.event_res = mhtq_pkg::RES_EXPIRED; e.expired_id = hid[0]; e.last = 1'b0;
            evt_q.push_back(e);
            n++;
          end
          hcount--;
          hk[0] = hk[hcount]; hid[0] = hid[hcount]; hlv[0] = hlv[hcount];
          heap_sift_down(0);
        end
        if (n > 0) begin
          e = evt_q[evt_q.size() - 1];
          e.last = 1'b1;
          evt_q[evt_q.size() - 1] = e;
        end
      end
    endcase
  endfunction

  // beat flags captured at the rising edge
  bit cmd_beat, evt_beat;
  always @(posedge clk) begin
    cmd_beat <= !rst && cmd.valid && cmd.ready;
    evt_beat <= !rst && evt.valid && evt.ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      cmd.valid       <= 1'b0;
      cmd.kind        <= mhtq_pkg::KIND_ADD;
      cmd.conn_id     <= '0;
      cmd.expire_time <= '0;
      cmd.now_time    <= '0;
      evt.ready       <= 1'b0;
    end else begin
      if (!cmd.valid || cmd_beat) begin
        if (cmd_q.size() > 0 && !hold_tx && (quiet || $urandom_range(99) >= 37)) begin
          {cmd.kind, cmd.conn_id, cmd.expire_time, cmd.now_time} <= cmd_q[0];
          cmd.valid <= 1'b1;
          void'(cmd_q.pop_front());
        end else begin
          cmd.valid <= 1'b0;
        end
      end
      evt.ready <= quiet || $urandom_range(99) >= 37;
    end
  end

  // monitor
  int idle_cycles;
  always @(posedge clk) begin
    timer_evt_t got, want;
    if (!rst) begin
      if ((cmd.valid && cmd.ready) || (evt.valid && evt.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (cmd.valid && cmd.ready) begin
        predict_timer_events({cmd.kind, cmd.conn_id, cmd.expire_time, cmd.now_time});
      end
      if (evt.valid && evt.ready) begin
        got = {evt.event_res, evt.expired_id, evt.last};
        if (evt_q.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %p", $time, got);
          errors++;
        end else begin
          want = evt_q.pop_front();
          if (got.event_res === mhtq_pkg::RES_FULL) n_full++; else n_evt++;
          if (got.event_res !== want.event_res)
            $display("%0t: event_res expected %0d actual %0d", $time,
                     want.event_res, got.event_res);
          if (got.expired_id !== want.expired_id)
            $display("%0t: expired_id expected %h actual %h", $time,
                     want.expired_id, got.expired_id);
          if (got.last !== want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      if (idle_cycles > 20000) begin
        $display("%0t: watchdog expired", $time);
        $display("** min_heap_timer_queue: FAILED **");
        $finish;
      end
    end
  end

  function automatic cmd_t mk(mhtq_pkg::kind_t k, logic [IdW-1:0] id,
                              logic [KeyW-1:0] ex, logic [KeyW-1:0] nw);
    cmd_t c;
    c.kind = k; c.conn_id = id; c.expire_time = ex; c.now_time = nw;
    return c;
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || cmd.valid) @(posedge clk);
    while (evt_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [KeyW-1:0] base;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ties, cancel, adjust, full heap
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h1234, '1, '1));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, 16'h0000, 32'h0, '1));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, 16'h0005, 32'd10, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, 16'h0006, 32'd10, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, 16'h0005, 32'd20, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_CANCEL, 16'h0006, '1, '1));
    cmd_q.push_back(mk(mhtq_pkg::KIND_CANCEL, 16'hAAAA, 32'h0, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADJUST, 16'h0005, 32'd3, '1));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADJUST, 16'h0000, 32'd50, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_ADJUST, 16'h7777, 32'd1, 32'h0));
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h0, '1, 32'd2));
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h0, 32'h0, 32'd25));
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'hFFFF, 32'h0, '1));
    drain();
    // fill the heap past capacity, then pop with the 64-result cap
    quiet = 1'b1;
    for (int i = 0; i < Capacity + 2; i++)
      cmd_q.push_back(mk(mhtq_pkg::KIND_ADD, IdW'($urandom), $urandom_range(100),
                         $urandom));
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h0, 32'h0, '1));
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h0, 32'h0, '1));
    drain();
    quiet = 1'b0;

    // random: mostly adds and ticks on a moving clock, small id pool
    base = 32'd1000;
    for (int i = 0; i < 220; i++) begin
      r = $urandom_range(99);
      if (i == 150) begin
        drain();
        hold_tx = 1'b1;  // sender waits out every pending event
        repeat (50) @(posedge clk);
        hold_tx = 1'b0;
      end
      if (i >= 100 && i < 160) quiet = 1'b1; else quiet = 1'b0;
      if (r < 3)
        cmd_q.push_back(mk(mhtq_pkg::kind_t'(2'($urandom_range(3))), IdW'($urandom),
                           $urandom, $urandom));
      else if (r < 50)
        cmd_q.push_back(mk(mhtq_pkg::KIND_ADD,
                           IdW'($urandom_range(15) | ($urandom_range(1) << 15)),
                           base + $urandom_range(200), $urandom));
      else if (r < 62)
        cmd_q.push_back(mk(mhtq_pkg::KIND_CANCEL, IdW'($urandom_range(15)), $urandom,
                           $urandom));
      else if (r < 74)
        cmd_q.push_back(mk(mhtq_pkg::KIND_ADJUST, IdW'($urandom_range(15)),
                           base + $urandom_range(300), $urandom));
      else begin
        base = base + $urandom_range(60);
        cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, IdW'($urandom), $urandom, base));
      end
      while (cmd_q.size() > 4) @(posedge clk);
    end
    cmd_q.push_back(mk(mhtq_pkg::KIND_TICK, 16'h0, 32'h0, '1));
    drain();

    $display("Ran %0d expiry events and %0d rejected adds over directed and random",
             n_evt, n_full);
    $display("command streams with heap full, ties, lazy cancel and adjusts.");
    if (errors == 0) begin
      $display("** min_heap_timer_queue: PASSED **");
    end else begin
      $display("** min_heap_timer_queue: FAILED **");
    end
    $finish;
  end
endmodule

/* files.f */
design/mhtq_pkg.sv
design/mhtq_if.sv
design/mhtq_ram.sv
design/min_heap_timer_queue.sv
dv/testbench.sv
